>>> rtl/pfmdec_pkg.sv
// Package with the constants and result type of the PFM stream decoder.
package pfmdec_pkg;

    localparam int unsigned DEF_MAX_RASTER_BYTES = 67108864;
    localparam int unsigned DEF_TOKEN_LIMIT      = 64;

    localparam int unsigned DIM_W = 23;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_OK     = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_HEADER    = 4'd1;
    localparam logic [3:0] ERR_TOKEN     = 4'd2;
    localparam logic [3:0] ERR_MAGIC     = 4'd3;
    localparam logic [3:0] ERR_WIDTH     = 4'd4;
    localparam logic [3:0] ERR_HEIGHT    = 4'd5;
    localparam logic [3:0] ERR_SCALE     = 4'd6;
    localparam logic [3:0] ERR_TOO_LARGE = 4'd7;
    localparam logic [3:0] ERR_SEPARATOR = 4'd8;
    localparam logic [3:0] ERR_TRUNCATED = 4'd9;
    localparam logic [3:0] ERR_TRAILING  = 4'd10;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       code;
        logic             nonfinite;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] texel;
        logic [1:0]       chan;
        logic [31:0]      bits;
        logic             last;
    } t_res;

endpackage

>>> rtl/pfm_float_image_stream_decoder.sv
// Top level of the PFM stream decoder: header parser, raster packer, result buffer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  input   | in        | i_in_valid / o_in_ready    | i_data_byte, i_end_of_file
//  output  | out       | o_out_valid / i_out_ready  | o_result_kind ... o_last_of_item
//
// Each input beat is decoded in the cycle it is accepted and its results land in the output
// register and a one-entry spill register, so one byte per clock is taken while results flow
// and no spill is pending. A beat with two results holds the input until its spill entry
// moves to the single output port. Reset is synchronous and active low; after a status result
// all input is taken and dropped until reset. Output stalls back up into o_in_ready.
module pfm_float_image_stream_decoder #(
    parameter int unsigned MAX_RASTER_BYTES = pfmdec_pkg::DEF_MAX_RASTER_BYTES,
    parameter int unsigned TOKEN_LIMIT      = pfmdec_pkg::DEF_TOKEN_LIMIT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_file,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_result_kind,
    output logic [3:0]                    o_error_code,
    output logic                          o_nonfinite_error,
    output logic [pfmdec_pkg::DIM_W-1:0]  o_image_width_out,
    output logic [pfmdec_pkg::DIM_W-1:0]  o_image_height_out,
    output logic [pfmdec_pkg::DIM_W-1:0]  o_texel_index,
    output logic [1:0]                    o_channel,
    output logic [31:0]                   o_sample_bits,
    output logic                          o_last_of_item
);
    import pfmdec_pkg::*;

    localparam logic [63:0] DIM_LIMIT = 64'(MAX_RASTER_BYTES / 12);
    localparam int unsigned DW = $clog2(MAX_RASTER_BYTES / 12 + 1);
    localparam int unsigned AW = 2 * DW;
    localparam int unsigned RW = $clog2(MAX_RASTER_BYTES + 1);
    localparam int unsigned LW = $clog2(TOKEN_LIMIT + 1);

    typedef enum logic [3:0] {
        PH_MAGIC_SEP, PH_MAGIC_TOK, PH_WIDTH_SEP, PH_WIDTH_TOK, PH_HEIGHT_SEP,
        PH_HEIGHT_TOK, PH_SCALE_SEP, PH_SCALE_TOK, PH_RASTER, PH_DONE
    } t_phase;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd12
            || c == 8'd11;
    endfunction

    function automatic t_res mk(input logic [1:0] kind, input logic [3:0] code,
                                input logic nf);
        t_res e;
        e = '0;
        e.kind = kind;
        e.code = code;
        e.nonfinite = nf;
        return e;
    endfunction

    t_phase        r_phase, n_phase;
    logic          r_comment, n_comment;
    logic [LW-1:0] r_len, n_len;
    logic [2:0]    r_match, n_match;
    logic [63:0]   r_val, n_val;
    logic          r_ovf, n_ovf;
    logic [DW-1:0] r_width, n_width;
    logic [DW-1:0] r_height, n_height;
    logic          r_too_large, n_too_large;
    logic          r_big, n_big;
    logic [23:0]   r_word, n_word;
    logic [1:0]    r_biw, n_biw;
    logic [1:0]    r_chan, n_chan;
    logic [DW-1:0] r_col, n_col;
    logic [DW-1:0] r_row, n_row;
    logic [RW-1:0] r_seen, n_seen;
    logic          r_nf, n_nf;
    logic [AW-1:0] r_area;
    logic [RW-1:0] r_total;

    t_res          r_out, r_spill, n_out, n_spill;
    logic          r_out_v, r_spill_v, n_out_v, n_spill_v;

    logic          accept;
    logic          out_fire;
    t_res          res [2];
    logic [1:0]    nres;

    // Token append and close helpers.
    t_phase        a_phase;
    logic [LW-1:0] a_len_in, ap_len;
    logic [2:0]    a_match_in, ap_match;
    logic [63:0]   a_val_in, ap_val;
    logic          a_ovf_in, ap_ovf, ap_long;
    logic [67:0]   mul10;
    logic [LW-1:0] c_len;
    logic [2:0]    c_match;
    logic [63:0]   c_val;
    logic          c_ovf;
    logic [3:0]    c_code;
    logic          dim_ok, dim_big;
    logic [31:0]   raw_word, swp_word;
    logic [7:0]    c;

    assign c = i_data_byte;
    assign out_fire = r_out_v && i_out_ready;
    assign o_in_ready = !r_spill_v && (!r_out_v || i_out_ready);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        a_phase    = r_phase;
        a_len_in   = r_len;
        a_match_in = r_match;
        a_val_in   = r_val;
        a_ovf_in   = r_ovf;
        if (r_phase == PH_MAGIC_SEP || r_phase == PH_WIDTH_SEP || r_phase == PH_HEIGHT_SEP
            || r_phase == PH_SCALE_SEP) begin
            a_phase    = t_phase'(r_phase + 4'd1);
            a_len_in   = '0;
            a_match_in = 3'b111;
            a_val_in   = '0;
            a_ovf_in   = 1'b0;
        end
        ap_len   = a_len_in;
        ap_match = a_match_in;
        ap_val   = a_val_in;
        ap_ovf   = a_ovf_in;
        ap_long  = 1'b0;
        mul10    = {4'd0, a_val_in} * 68'd10 + {60'd0, c - 8'd48};
        if (a_len_in >= LW'(TOKEN_LIMIT)) begin
            ap_long = 1'b1;
        end else begin
            if (a_phase == PH_MAGIC_TOK) begin
                if (!((a_len_in == LW'(0) && c == "P") || (a_len_in == LW'(1) && c == "F")))
                    ap_match[0] = 1'b0;
            end else if (a_phase == PH_SCALE_TOK) begin
                if (!((a_len_in == LW'(0) && c == "-") || (a_len_in == LW'(1) && c == "1")
                    || (a_len_in == LW'(2) && c == ".") || (a_len_in == LW'(3) && c == "0")))
                    ap_match[0] = 1'b0;
                if (!((a_len_in == LW'(0) && c == "1") || (a_len_in == LW'(1) && c == ".")
                    || (a_len_in == LW'(2) && c == "0")))
                    ap_match[1] = 1'b0;
            end else begin
                if (c >= "0" && c <= "9") begin
                    if (!a_ovf_in) begin
                        if (mul10[67:64] != 4'd0) ap_ovf = 1'b1;
                        else ap_val = mul10[63:0];
                    end
                end else begin
                    ap_match[0] = 1'b0;
                end
            end
            ap_len = a_len_in + LW'(1);
        end
    end

    always_comb begin
        if ((r_phase == PH_MAGIC_TOK || r_phase == PH_WIDTH_TOK || r_phase == PH_HEIGHT_TOK
            || r_phase == PH_SCALE_TOK) && is_space(c)) begin
            c_len = r_len; c_match = r_match; c_val = r_val; c_ovf = r_ovf;
        end else begin
            c_len = ap_len; c_match = ap_match; c_val = ap_val; c_ovf = ap_ovf;
        end
        dim_ok  = c_match[0] && !c_ovf && c_val != 64'd0;
        dim_big = c_val > DIM_LIMIT;
        unique case (a_phase)
            PH_MAGIC_TOK:  c_code = (c_match[0] && c_len == LW'(2)) ? ERR_NONE : ERR_MAGIC;
            PH_WIDTH_TOK:  c_code = dim_ok ? ERR_NONE : ERR_WIDTH;
            PH_HEIGHT_TOK: c_code = dim_ok ? ERR_NONE : ERR_HEIGHT;
            default: begin
                if (!((c_match[0] && c_len == LW'(4)) || (c_match[1] && c_len == LW'(3))))
                    c_code = ERR_SCALE;
                else if (r_too_large || 64'(r_area) > DIM_LIMIT)
                    c_code = ERR_TOO_LARGE;
                else
                    c_code = ERR_NONE;
            end
        endcase
    end

    assign raw_word = {r_word, c};
    assign swp_word = r_big ? raw_word : {c, r_word[7:0], r_word[15:8], r_word[23:16]};

    always_comb begin
        n_phase = r_phase; n_comment = r_comment; n_len = r_len; n_match = r_match;
        n_val = r_val; n_ovf = r_ovf; n_width = r_width; n_height = r_height;
        n_too_large = r_too_large; n_big = r_big; n_word = r_word; n_biw = r_biw;
        n_chan = r_chan; n_col = r_col; n_row = r_row; n_seen = r_seen; n_nf = r_nf;
        res[0] = '0;
        res[1] = '0;
        nres = 2'd0;

        // Width check side effect, applied on every byte taken in the width phases, not only at a close.
        if (a_phase == PH_WIDTH_TOK && dim_ok) begin
            if (dim_big) n_too_large = 1'b1;
        end

        unique case (r_phase)
            PH_DONE: begin
            end
            PH_RASTER: begin
                if (r_seen >= r_total) begin
                    res[0] = mk(KIND_ERROR, ERR_TRAILING, 1'b0);
                    nres = 2'd1;
                    n_phase = PH_DONE;
                end else begin
                    n_seen = r_seen + RW'(1);
                    if (r_biw != 2'd3) begin
                        n_word = {r_word[15:0], c};
                        n_biw = r_biw + 2'd1;
                    end else begin
                        if (swp_word[30:23] == 8'hFF) n_nf = 1'b1;
                        res[0] = mk(KIND_SAMPLE, ERR_NONE, 1'b0);
                        res[0].texel = DIM_W'(r_row + r_col);
                        res[0].chan = r_chan;
                        res[0].bits = swp_word;
                        nres = 2'd1;
                        n_biw = 2'd0;
                        n_word = '0;
                        if (r_chan == 2'd2) begin
                            n_chan = 2'd0;
                            if (r_col + DW'(1) >= r_width) begin
                                n_col = '0;
                                n_row = (r_row >= r_width) ? r_row - r_width : '0;
                            end else begin
                                n_col = r_col + DW'(1);
                            end
                        end else begin
                            n_chan = r_chan + 2'd1;
                        end
                    end
                    if (i_end_of_file) begin
                        n_phase = PH_DONE;
                        if (n_seen < r_total)
                            res[nres[0]] = mk(KIND_ERROR, ERR_TRUNCATED, 1'b0);
                        else if (n_nf)
                            res[nres[0]] = mk(KIND_ERROR, ERR_NONE, 1'b1);
                        else
                            res[nres[0]] = mk(KIND_OK, ERR_NONE, 1'b0);
                        nres = nres + 2'd1;
                    end
                end
            end
            PH_MAGIC_SEP, PH_WIDTH_SEP, PH_HEIGHT_SEP, PH_SCALE_SEP: begin
                if (r_comment) begin
                    if (c == 8'd10) n_comment = 1'b0;
                    if (i_end_of_file) begin
                        res[0] = mk(KIND_ERROR, ERR_HEADER, 1'b0);
                        nres = 2'd1;
                        n_phase = PH_DONE;
                    end
                end else if (is_space(c) || c == "#") begin
                    if (c == "#") n_comment = 1'b1;
                    if (i_end_of_file) begin
                        res[0] = mk(KIND_ERROR, ERR_HEADER, 1'b0);
                        nres = 2'd1;
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_phase = a_phase;
                    n_len = ap_len; n_match = ap_match; n_val = ap_val; n_ovf = ap_ovf;
                    if (ap_long) begin
                        res[0] = mk(KIND_ERROR, ERR_TOKEN, 1'b0);
                        nres = 2'd1;
                        n_phase = PH_DONE;
                    end else if (i_end_of_file) begin
                        res[0] = mk(KIND_ERROR, (c_code != ERR_NONE) ? c_code
                            : ((a_phase == PH_SCALE_TOK) ? ERR_SEPARATOR : ERR_HEADER), 1'b0);
                        nres = 2'd1;
                        n_phase = PH_DONE;
                    end
                end
            end
            default: begin
                if (is_space(c)) begin
                    if (c_code != ERR_NONE) begin
                        res[0] = mk(KIND_ERROR, c_code, 1'b0);
                        nres = 2'd1;
                        n_phase = PH_DONE;
                    end else if (r_phase == PH_SCALE_TOK) begin
                        n_phase = PH_RASTER;
                        n_big = !(c_match[0] && c_len == LW'(4));
                        n_word = '0; n_biw = 2'd0; n_chan = 2'd0; n_col = '0;
                        n_seen = '0; n_nf = 1'b0;
                        n_row = DW'(r_area - AW'(r_width));
                        res[0] = mk(KIND_HEADER, ERR_NONE, 1'b0);
                        res[0].width = DIM_W'(r_width);
                        res[0].height = DIM_W'(r_height);
                        nres = 2'd1;
                        if (i_end_of_file) begin
                            res[1] = mk(KIND_ERROR, ERR_TRUNCATED, 1'b0);
                            nres = 2'd2;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_phase = t_phase'(r_phase + 4'd1);
                        n_comment = 1'b0;
                        if (r_phase == PH_WIDTH_TOK) n_width = dim_big ? '0 : DW'(c_val);
                        if (r_phase == PH_HEIGHT_TOK) begin
                            n_height = dim_big ? '0 : DW'(c_val);
                            if (dim_big) n_too_large = 1'b1;
                        end
                        if (i_end_of_file) begin
                            res[0] = mk(KIND_ERROR, ERR_HEADER, 1'b0);
                            nres = 2'd1;
                            n_phase = PH_DONE;
                        end
                    end
                end else begin
                    n_len = ap_len; n_match = ap_match; n_val = ap_val; n_ovf = ap_ovf;
                    if (ap_long) begin
                        res[0] = mk(KIND_ERROR, ERR_TOKEN, 1'b0);
                        nres = 2'd1;
                        n_phase = PH_DONE;
                    end else if (i_end_of_file) begin
                        res[0] = mk(KIND_ERROR, (c_code != ERR_NONE) ? c_code
                            : ((r_phase == PH_SCALE_TOK) ? ERR_SEPARATOR : ERR_HEADER), 1'b0);
                        nres = 2'd1;
                        n_phase = PH_DONE;
                    end
                end
            end
        endcase

        if (nres == 2'd2) res[1].last = 1'b1;
        else res[0].last = 1'b1;
    end

    always_comb begin
        n_out = r_out; n_spill = r_spill; n_out_v = r_out_v; n_spill_v = r_spill_v;
        if (accept) begin
            n_out = res[0];
            n_out_v = nres != 2'd0;
            n_spill = res[1];
            n_spill_v = nres == 2'd2;
        end else if (out_fire) begin
            n_out = r_spill;
            n_out_v = r_spill_v;
            n_spill_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_area  <= AW'(r_width) * AW'(r_height);
        r_total <= RW'({4'd0, r_area} * (AW + 4)'(12));
        r_out   <= n_out;
        r_spill <= n_spill;
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC_SEP; r_comment <= 1'b0; r_len <= '0; r_match <= '0;
            r_ovf <= 1'b0; r_width <= '0; r_height <= '0;
            r_too_large <= 1'b0; r_big <= 1'b0; r_biw <= '0; r_chan <= '0;
            r_col <= '0; r_row <= '0; r_seen <= '0; r_nf <= 1'b0;
            r_out_v <= 1'b0; r_spill_v <= 1'b0;
            r_val <= '0; r_word <= '0;
        end else begin
            r_out_v <= n_out_v;
            r_spill_v <= n_spill_v;
            if (accept) begin
                r_phase <= n_phase; r_comment <= n_comment; r_len <= n_len;
                r_match <= n_match; r_ovf <= n_ovf; r_width <= n_width;
                r_height <= n_height; r_too_large <= n_too_large; r_big <= n_big;
                r_biw <= n_biw; r_chan <= n_chan; r_col <= n_col; r_row <= n_row;
                r_seen <= n_seen; r_nf <= n_nf;
                r_val <= n_val; r_word <= n_word;
            end
        end
    end

    assign o_out_valid        = r_out_v;
    assign o_result_kind      = r_out.kind;
    assign o_error_code       = r_out.code;
    assign o_nonfinite_error  = r_out.nonfinite;
    assign o_image_width_out  = r_out.width;
    assign o_image_height_out = r_out.height;
    assign o_texel_index      = r_out.texel;
    assign o_channel          = r_out.chan;
    assign o_sample_bits      = r_out.bits;
    assign o_last_of_item     = r_out.last;

endmodule
